[design/sbcc_pkg.sv]
// Shared types and constants for the segment/box collision checker.
// No dependencies; every other design file imports this package.
package sbcc_pkg;

  localparam int COORD_BITS = 24;
  localparam int CLR_BITS   = 20;
  localparam int RAD_BITS   = 23;
  localparam int CFG_BITS   = (COORD_BITS > CLR_BITS) ? COORD_BITS : CLR_BITS;
  localparam int IDX_BITS   = 3;
  // grown bound: min corner minus clearance, max corner plus clearance
  localparam int BND_BITS   = ((COORD_BITS > CLR_BITS + 1) ? COORD_BITS : CLR_BITS + 1) + 1;
  localparam int DIF_BITS   = BND_BITS + 1;
  localparam int PRD_BITS   = 2 * DIF_BITS;
  localparam int SUM_BITS   = PRD_BITS + 1;
  localparam int R2_BITS    = 2 * RAD_BITS;

  typedef enum logic [IDX_BITS-1:0] {
    REG_CORNER_A_X = 3'd0,
    REG_CORNER_A_Y = 3'd1,
    REG_CORNER_B_X = 3'd2,
    REG_CORNER_B_Y = 3'd3,
    REG_CLEARANCE  = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CAUSE_NONE   = 2'd0,
    CAUSE_EDGE   = 2'd1,
    CAUSE_INSIDE = 2'd2,
    CAUSE_NEAR   = 2'd3
  } cause_t;

  typedef struct packed {
    logic                         mode;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic        [RAD_BITS-1:0]   radius;
  } in_item_t;

  typedef struct packed {
    logic   hit;
    cause_t cause;
  } out_item_t;

  typedef struct packed {
    logic signed [BND_BITS-1:0] lox;
    logic signed [BND_BITS-1:0] hix;
    logic signed [BND_BITS-1:0] loy;
    logic signed [BND_BITS-1:0] hiy;
  } box_t;

  // per-item facts needed next to the products for the crossing test
  typedef struct packed {
    logic ax_nz;
    logic ax_neg;
    logic ay_nz;
    logic ay_neg;
    logic wx_nz;
    logic wy_nz;
    logic lox_in;
    logic hix_in;
    logic loy_in;
    logic hiy_in;
    logic start_in;
  } seg_flags_t;

  typedef struct packed {
    logic                       mode;
    seg_flags_t                 flags;
    logic signed [PRD_BITS-1:0] p1;
    logic signed [PRD_BITS-1:0] p2;
    logic signed [PRD_BITS-1:0] p3;
    logic signed [PRD_BITS-1:0] p4;
    logic        [R2_BITS-1:0]  r2;
  } mul_out_t;

endpackage

[design/segment_box_collision_check_top.sv]
// Top level of the segment/box collision checker: input register, handshake
// control and the box, product and decision stages. Uses sbcc_pkg.
//
// Takes one item per clock while not stalled and returns one result per item,
// in order. Three registers sit on the path (input register, product register,
// result register); out_valid is the valid flag of the result register.
// Throughput is one item per cycle, since every stage advances on each
// clock that the consumer does not stall. The grown box is registered from the
// configuration, so it follows a register write through the configuration
// register and then the box register. Ready falls only when the result
// register is held by a stalled consumer and the earlier stages are full.
module segment_box_collision_check_top
  import sbcc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_data
);

  logic     v1, v2, v3;
  logic     ready2, ready3;
  in_item_t item;
  box_t     box;
  mul_out_t prod;

  assign ready3    = !v3 || out_ready;
  assign ready2    = !v2 || ready3;
  assign in_ready  = !v1 || ready2;
  assign out_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (in_ready) begin
        v1 <= in_valid;
      end
      if (ready2) begin
        v2 <= v1;
      end
      if (ready3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
  end

  sbcc_box u_box (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .box       (box)
  );

  sbcc_mul u_mul (
    .clk  (clk),
    .en   (ready2),
    .item (item),
    .box  (box),
    .prod (prod)
  );

  sbcc_eval u_eval (
    .clk    (clk),
    .en     (ready3),
    .prod   (prod),
    .result (out_data)
  );

endmodule

[design/sbcc_box.sv]
// Configuration registers and the registered grown obstacle box.
// Depends on sbcc_pkg.
module sbcc_box
  import sbcc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data,
  output box_t                box
);

  logic signed [COORD_BITS-1:0] corner_a_x, corner_a_y, corner_b_x, corner_b_y;
  logic        [CLR_BITS-1:0]   clearance;

  logic signed [BND_BITS-1:0] ax_w, ay_w, bx_w, by_w, clr_w;
  box_t                       box_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_a_x <= '0;
      corner_a_y <= '0;
      corner_b_x <= '0;
      corner_b_y <= '0;
      clearance  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CORNER_A_X: corner_a_x <= $signed(cfg_data[COORD_BITS-1:0]);
        REG_CORNER_A_Y: corner_a_y <= $signed(cfg_data[COORD_BITS-1:0]);
        REG_CORNER_B_X: corner_b_x <= $signed(cfg_data[COORD_BITS-1:0]);
        REG_CORNER_B_Y: corner_b_y <= $signed(cfg_data[COORD_BITS-1:0]);
        REG_CLEARANCE:  clearance  <= cfg_data[CLR_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign ax_w  = BND_BITS'(corner_a_x);
  assign ay_w  = BND_BITS'(corner_a_y);
  assign bx_w  = BND_BITS'(corner_b_x);
  assign by_w  = BND_BITS'(corner_b_y);
  assign clr_w = BND_BITS'(clearance);

  always_comb begin
    box_next.lox = ((ax_w < bx_w) ? ax_w : bx_w) - clr_w;
    box_next.hix = ((ax_w < bx_w) ? bx_w : ax_w) + clr_w;
    box_next.loy = ((ay_w < by_w) ? ay_w : by_w) - clr_w;
    box_next.hiy = ((ay_w < by_w) ? by_w : ay_w) + clr_w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      box <= '0;
    end else begin
      box <= box_next;
    end
  end

endmodule

[design/sbcc_mul.sv]
// Product stage: coordinate differences, four shared multipliers and the
// radius square, plus the range flags for the crossing test. Uses sbcc_pkg.
module sbcc_mul
  import sbcc_pkg::*;
(
  input  logic     clk,
  input  logic     en,
  input  in_item_t item,
  input  box_t     box,
  output mul_out_t prod
);

  logic signed [DIF_BITS-1:0] sx, sy, ex, ey, lox, hix, loy, hiy;
  logic signed [DIF_BITS-1:0] ax, ay, dlx, dhx, dly, dhy;
  logic signed [DIF_BITS-1:0] a1, a2, a3, a4;
  mul_out_t                   prod_next;

  assign sx  = DIF_BITS'($signed(item.start_x));
  assign sy  = DIF_BITS'($signed(item.start_y));
  assign ex  = DIF_BITS'($signed(item.end_x));
  assign ey  = DIF_BITS'($signed(item.end_y));
  assign lox = DIF_BITS'($signed(box.lox));
  assign hix = DIF_BITS'($signed(box.hix));
  assign loy = DIF_BITS'($signed(box.loy));
  assign hiy = DIF_BITS'($signed(box.hiy));

  assign ax  = ex - sx;
  assign ay  = ey - sy;
  assign dlx = lox - sx;
  assign dhx = hix - sx;
  assign dly = loy - sy;
  assign dhy = hiy - sy;

  // segment mode: cross terms against the start point; point mode: squares
  assign a1 = item.mode ? dlx : ay;
  assign a2 = item.mode ? dhx : ay;
  assign a3 = item.mode ? dly : ax;
  assign a4 = item.mode ? dhy : ax;

  always_comb begin
    prod_next.mode           = item.mode;
    prod_next.p1             = PRD_BITS'(a1) * PRD_BITS'(dlx);
    prod_next.p2             = PRD_BITS'(a2) * PRD_BITS'(dhx);
    prod_next.p3             = PRD_BITS'(a3) * PRD_BITS'(dly);
    prod_next.p4             = PRD_BITS'(a4) * PRD_BITS'(dhy);
    prod_next.r2             = R2_BITS'(item.radius) * R2_BITS'(item.radius);
    prod_next.flags.ax_nz    = (ax != '0);
    prod_next.flags.ax_neg   = ax[DIF_BITS-1];
    prod_next.flags.ay_nz    = (ay != '0);
    prod_next.flags.ay_neg   = ay[DIF_BITS-1];
    prod_next.flags.wx_nz    = (lox != hix);
    prod_next.flags.wy_nz    = (loy != hiy);
    prod_next.flags.lox_in   = ((sx <= lox) && (lox <= ex)) || ((ex <= lox) && (lox <= sx));
    prod_next.flags.hix_in   = ((sx <= hix) && (hix <= ex)) || ((ex <= hix) && (hix <= sx));
    prod_next.flags.loy_in   = ((sy <= loy) && (loy <= ey)) || ((ey <= loy) && (loy <= sy));
    prod_next.flags.hiy_in   = ((sy <= hiy) && (hiy <= ey)) || ((ey <= hiy) && (hiy <= sy));
    prod_next.flags.start_in = (lox < sx) && (sx < hix) && (loy < sy) && (sy < hiy);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= prod_next;
    end
  end

endmodule

[design/sbcc_eval.sv]
// Decision stage: edge crossing, start-inside and nearness compares into the result register.
// Uses sbcc_pkg.
module sbcc_eval
  import sbcc_pkg::*;
(
  input  logic      clk,
  input  logic      en,
  input  mul_out_t  prod,
  output out_item_t result
);

  logic signed [SUM_BITS-1:0] dlo, dhi, r2_w;
  logic                       h_lo, h_hi, v_lo, v_hi, near;
  seg_flags_t                 f;
  cause_t                     cause;
  out_item_t                  result_next;

  assign f = prod.flags;

  // Crossing on a horizontal edge at y: ay*(lox-sx) <= ax*(y-sy) <= ay*(hix-sx)
  // (order flips with the sign of ay); vertical edges mirror this with ax.
  assign h_lo = f.ay_nz && f.wx_nz && f.loy_in &&
                (f.ay_neg ? ((prod.p2 <= prod.p3) && (prod.p3 <= prod.p1))
                          : ((prod.p1 <= prod.p3) && (prod.p3 <= prod.p2)));
  assign h_hi = f.ay_nz && f.wx_nz && f.hiy_in &&
                (f.ay_neg ? ((prod.p2 <= prod.p4) && (prod.p4 <= prod.p1))
                          : ((prod.p1 <= prod.p4) && (prod.p4 <= prod.p2)));
  assign v_lo = f.ax_nz && f.wy_nz && f.lox_in &&
                (f.ax_neg ? ((prod.p4 <= prod.p1) && (prod.p1 <= prod.p3))
                          : ((prod.p3 <= prod.p1) && (prod.p1 <= prod.p4)));
  assign v_hi = f.ax_nz && f.wy_nz && f.hix_in &&
                (f.ax_neg ? ((prod.p4 <= prod.p2) && (prod.p2 <= prod.p3))
                          : ((prod.p3 <= prod.p2) && (prod.p2 <= prod.p4)));

  assign dlo  = SUM_BITS'(prod.p1) + SUM_BITS'(prod.p3);
  assign dhi  = SUM_BITS'(prod.p2) + SUM_BITS'(prod.p4);
  assign r2_w = SUM_BITS'(prod.r2);
  assign near = (dlo <= r2_w) || (dhi <= r2_w);

  always_comb begin
    if (prod.mode) begin
      cause = near ? CAUSE_NEAR : CAUSE_NONE;
    end else if (h_lo || h_hi || v_lo || v_hi) begin
      cause = CAUSE_EDGE;
    end else if (f.start_in) begin
      cause = CAUSE_INSIDE;
    end else begin
      cause = CAUSE_NONE;
    end
    result_next.cause = cause;
    result_next.hit   = (cause != CAUSE_NONE);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= result_next;
    end
  end

endmodule
